// ===== design/cpt_pkg.sv =====
`default_nettype none

package cpt_pkg;

   // Sample and angle widths
   localparam int DATA_WIDTH  = 16;
   localparam int ANGLE_WIDTH = 16;

   // Sine and cosine are Q1.15
   localparam int SINCOS_WIDTH = 16;
   localparam logic signed [SINCOS_WIDTH-1:0] Q15_MAX = 16'sd32767;
   localparam logic signed [SINCOS_WIDTH-1:0] Q15_MIN = -16'sd32767;

   // CORDIC: Q2.30 datapath with headroom, 32-bit turn angle plus sign
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_WIDTH = 34;
   localparam int PHASE_WIDTH  = 33;
   localparam logic [31:0] CORDIC_X0 = 32'd652032874;
   localparam logic [31:0] OCTANT_OFFSET = 32'h2000_0000;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
   };

   // Q0.16 scale factors
   localparam logic [15:0] INV_SQRT3_Q16  = 16'd37837;
   localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;

   typedef enum logic {
      MODE_FORWARD = 1'b0,
      MODE_INVERSE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                      mode;
      logic signed [DATA_WIDTH-1:0]  in_a;
      logic signed [DATA_WIDTH-1:0]  in_b;
      logic signed [DATA_WIDTH-1:0]  in_c;
      logic        [ANGLE_WIDTH-1:0] theta;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] out_alpha;
      logic signed [DATA_WIDTH-1:0] out_beta;
      logic signed [DATA_WIDTH-1:0] out_x;
      logic signed [DATA_WIDTH-1:0] out_y;
      logic signed [DATA_WIDTH-1:0] out_z;
      logic                         saturated;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/clarke_park_transform.sv =====
`default_nettype none

// Channel  | Valid      | Stall      | Payload
// ---------+------------+------------+-----------------------------
// request  | req_valid  | req_stall  | req_data (cpt_pkg::req_type)
// response | rsp_valid  | rsp_stall  | rsp_data (cpt_pkg::rsp_type)
//
// One transaction enters per cycle while no response is held; the pipeline is an input stage, one stage per
// CORDIC iteration (16), the sine/cosine stage, then six stages of multiply, add and saturate.
// The CORDIC chain sets the depth; no multiply in any stage is wider than 17x17.
// The whole pipeline freezes while a response waits under rsp_stall; req_stall follows it.
// Synchronous active-high reset clears the valid bits only.

module clarke_park_transform (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire cpt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output cpt_pkg::rsp_type      rsp_data
);

   localparam int D     = cpt_pkg::DATA_WIDTH;
   localparam int AW    = cpt_pkg::ANGLE_WIDTH;
   localparam int SW    = cpt_pkg::SINCOS_WIDTH;
   localparam int CW    = cpt_pkg::CORDIC_WIDTH;
   localparam int ZW    = cpt_pkg::PHASE_WIDTH;
   localparam int STEPS = cpt_pkg::CORDIC_STEPS;
   localparam int PW    = 2 * D + 4;

   localparam logic signed [PW-1:0] DATA_MAX = PW'((64'sd1 <<< (D - 1)) - 64'sd1);
   localparam logic signed [PW-1:0] DATA_MIN = -DATA_MAX - PW'(1);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   // Divide by 2^k, truncating toward zero
   function automatic logic signed [PW-1:0] div_pow2(input logic signed [PW-1:0] v,
                                                     input int unsigned k);
      logic signed [PW-1:0] bias;
      bias = v[PW-1] ? $signed((PW'(1) << k) - PW'(1)) : '0;
      return (v + bias) >>> k;
   endfunction

   function automatic logic is_over(input logic signed [PW-1:0] v);
      return (v > DATA_MAX) || (v < DATA_MIN);
   endfunction

   function automatic logic signed [D-1:0] sat_data(input logic signed [PW-1:0] v);
      logic signed [D-1:0] r;
      if (v > DATA_MAX) begin
         r = D'(DATA_MAX);
      end else if (v < DATA_MIN) begin
         r = D'(DATA_MIN);
      end else begin
         r = D'(v);
      end
      return r;
   endfunction

   // Round Q2.30 to Q1.15 and clamp symmetrically
   function automatic logic signed [SW-1:0] to_q15(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      logic signed [SW-1:0] q;
      r = (v + $signed(CW'(16384))) >>> 15;
      if (r > CW'(cpt_pkg::Q15_MAX)) begin
         q = cpt_pkg::Q15_MAX;
      end else if (r < CW'(cpt_pkg::Q15_MIN)) begin
         q = cpt_pkg::Q15_MIN;
      end else begin
         q = SW'(r);
      end
      return q;
   endfunction

   // Global advance: the pipeline moves unless the response is held
   logic adv_w;
   logic rsp_valid_ff;
   cpt_pkg::rsp_type rsp_data_ff;

   assign adv_w     = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv_w;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- CORDIC
   cpt_pkg::req_type        pay_ff  [0:STEPS];
   logic [1:0]              quad_ff [0:STEPS];
   logic signed [CW-1:0]    cx_ff   [0:STEPS];
   logic signed [CW-1:0]    cy_ff   [0:STEPS];
   logic signed [ZW-1:0]    cz_ff   [0:STEPS];
   logic                    cv_ff   [0:STEPS];

   logic [31:0]          ang_w;
   logic [31:0]          rot_w;
   logic signed [ZW-1:0] z0_w;

   // Fold the angle to one octant around the nearest axis
   assign ang_w = 32'(req_data.theta) << (32 - AW);
   assign rot_w = ang_w + cpt_pkg::OCTANT_OFFSET;
   assign z0_w  = $signed(ZW'(rot_w[29:0])) - $signed(ZW'(cpt_pkg::OCTANT_OFFSET));

   // Load the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv_w) begin
         cv_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         pay_ff[0]  <= req_data;
         quad_ff[0] <= rot_w[31:30];
         cx_ff[0]   <= $signed(CW'(cpt_pkg::CORDIC_X0));
         cy_ff[0]   <= '0;
         cz_ff[0]   <= z0_w;
      end
   end

   // One micro-rotation per stage
   for (genvar gi = 0; gi < STEPS; gi++) begin : g_iter
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [ZW-1:0] z_in;
      logic signed [ZW-1:0] atan_w;

      assign atan_w = $signed(ZW'(cpt_pkg::ATAN_TABLE[gi]));

      always_comb begin
         if (cz_ff[gi] >= 0) begin
            x_in = cx_ff[gi] - (cy_ff[gi] >>> gi);
            y_in = cy_ff[gi] + (cx_ff[gi] >>> gi);
            z_in = cz_ff[gi] - atan_w;
         end else begin
            x_in = cx_ff[gi] + (cy_ff[gi] >>> gi);
            y_in = cy_ff[gi] - (cx_ff[gi] >>> gi);
            z_in = cz_ff[gi] + atan_w;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[gi+1] <= 1'b0;
         end else if (adv_w) begin
            cv_ff[gi+1] <= cv_ff[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (adv_w) begin
            pay_ff[gi+1]  <= pay_ff[gi];
            quad_ff[gi+1] <= quad_ff[gi];
            cx_ff[gi+1]   <= x_in;
            cy_ff[gi+1]   <= y_in;
            cz_ff[gi+1]   <= z_in;
         end
      end
   end

   // ------------------------------------------------------ sine and cosine
   logic signed [SW-1:0] c_w, s_w, cs_in, sn_in;
   logic signed [D:0]    diff_in;

   logic                 sa_v_ff;
   cpt_pkg::mode_type    sa_mode_ff;
   logic signed [D-1:0]  sa_a_ff, sa_b_ff;
   logic signed [D:0]    sa_diff_ff;
   logic signed [SW-1:0] sa_cs_ff, sa_sn_ff;

   assign c_w = to_q15(cx_ff[STEPS]);
   assign s_w = to_q15(cy_ff[STEPS]);

   // Map back to the quadrant; negate sine for the inverse rotation
   always_comb begin
      case (quad_ff[STEPS])
         QUAD_0: begin cs_in = c_w;  sn_in = s_w;  end
         QUAD_1: begin cs_in = -s_w; sn_in = c_w;  end
         QUAD_2: begin cs_in = -c_w; sn_in = -s_w; end
         default: begin cs_in = s_w; sn_in = -c_w; end
      endcase
      if (pay_ff[STEPS].mode == cpt_pkg::MODE_INVERSE) begin
         sn_in = -sn_in;
      end
      diff_in = (D+1)'(pay_ff[STEPS].in_b) - (D+1)'(pay_ff[STEPS].in_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_v_ff <= 1'b0;
      end else if (adv_w) begin
         sa_v_ff <= cv_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         sa_mode_ff <= pay_ff[STEPS].mode;
         sa_a_ff    <= pay_ff[STEPS].in_a;
         sa_b_ff    <= pay_ff[STEPS].in_b;
         sa_diff_ff <= diff_in;
         sa_cs_ff   <= cs_in;
         sa_sn_ff   <= sn_in;
      end
   end

   // ------------------------------------------------- stage 1: (b-c)/sqrt3
   logic signed [D+17:0] beta_prod_w;

   logic                 s1_v_ff;
   cpt_pkg::mode_type    s1_mode_ff;
   logic signed [D-1:0]  s1_a_ff, s1_b_ff;
   logic signed [PW-1:0] s1_prod_ff;
   logic signed [SW-1:0] s1_cs_ff, s1_sn_ff;

   assign beta_prod_w = sa_diff_ff * $signed({1'b0, cpt_pkg::INV_SQRT3_Q16});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv_w) begin
         s1_v_ff <= sa_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         s1_mode_ff <= sa_mode_ff;
         s1_a_ff    <= sa_a_ff;
         s1_b_ff    <= sa_b_ff;
         s1_prod_ff <= PW'(beta_prod_w);
         s1_cs_ff   <= sa_cs_ff;
         s1_sn_ff   <= sa_sn_ff;
      end
   end

   // ------------------------------------- stage 2: pick the rotation input
   logic signed [PW-1:0] beta_q_w;
   logic signed [D-1:0]  v_in;
   logic                 flag2_in;

   logic                 s2_v_ff;
   cpt_pkg::mode_type    s2_mode_ff;
   logic signed [D-1:0]  s2_u_ff, s2_v2_ff;
   logic                 s2_flag_ff;
   logic signed [SW-1:0] s2_cs_ff, s2_sn_ff;

   assign beta_q_w = div_pow2(s1_prod_ff, 16);

   always_comb begin
      if (s1_mode_ff == cpt_pkg::MODE_FORWARD) begin
         v_in     = sat_data(beta_q_w);
         flag2_in = is_over(beta_q_w);
      end else begin
         v_in     = s1_b_ff;
         flag2_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv_w) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         s2_mode_ff <= s1_mode_ff;
         s2_u_ff    <= s1_a_ff;
         s2_v2_ff   <= v_in;
         s2_flag_ff <= flag2_in;
         s2_cs_ff   <= s1_cs_ff;
         s2_sn_ff   <= s1_sn_ff;
      end
   end

   // ------------------------------------------- stage 3: rotation products
   logic signed [D+SW-1:0] ucs_w, vsn_w, vcs_w, usn_w;

   logic                 s3_v_ff;
   cpt_pkg::mode_type    s3_mode_ff;
   logic signed [D-1:0]  s3_u_ff, s3_v2_ff;
   logic                 s3_flag_ff;
   logic signed [PW-1:0] s3_ucs_ff, s3_vsn_ff, s3_vcs_ff, s3_usn_ff;

   assign ucs_w = s2_u_ff * s2_cs_ff;
   assign vsn_w = s2_v2_ff * s2_sn_ff;
   assign vcs_w = s2_v2_ff * s2_cs_ff;
   assign usn_w = s2_u_ff * s2_sn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv_w) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         s3_mode_ff <= s2_mode_ff;
         s3_u_ff    <= s2_u_ff;
         s3_v2_ff   <= s2_v2_ff;
         s3_flag_ff <= s2_flag_ff;
         s3_ucs_ff  <= PW'(ucs_w);
         s3_vsn_ff  <= PW'(vsn_w);
         s3_vcs_ff  <= PW'(vcs_w);
         s3_usn_ff  <= PW'(usn_w);
      end
   end

   // ------------------------------------- stage 4: rotation sums, saturate
   logic signed [PW-1:0] rot1_w, rot2_w;
   logic signed [D-1:0]  alpha_in, beta_in, x_in, y_in;
   logic                 flag4_in;

   logic                 s4_v_ff;
   cpt_pkg::mode_type    s4_mode_ff;
   logic signed [D-1:0]  s4_alpha_ff, s4_beta_ff, s4_x_ff, s4_y_ff;
   logic                 s4_flag_ff;

   assign rot1_w = div_pow2(s3_ucs_ff + s3_vsn_ff, 15);
   assign rot2_w = div_pow2(s3_vcs_ff - s3_usn_ff, 15);

   always_comb begin
      x_in     = sat_data(rot1_w);
      y_in     = sat_data(rot2_w);
      flag4_in = s3_flag_ff | is_over(rot1_w) | is_over(rot2_w);
      if (s3_mode_ff == cpt_pkg::MODE_FORWARD) begin
         alpha_in = s3_u_ff;
         beta_in  = s3_v2_ff;
      end else begin
         alpha_in = x_in;
         beta_in  = y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv_w) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         s4_mode_ff  <= s3_mode_ff;
         s4_alpha_ff <= alpha_in;
         s4_beta_ff  <= beta_in;
         s4_x_ff     <= x_in;
         s4_y_ff     <= y_in;
         s4_flag_ff  <= flag4_in;
      end
   end

   // ------------------------------ stage 5: inverse Clarke products
   logic signed [D+16:0] pb_w;

   logic                 s5_v_ff;
   cpt_pkg::mode_type    s5_mode_ff;
   logic signed [D-1:0]  s5_alpha_ff, s5_beta_ff, s5_x_ff, s5_y_ff;
   logic                 s5_flag_ff;
   logic signed [PW-1:0] s5_pb_ff, s5_pa_ff;

   assign pb_w = s4_beta_ff * $signed({1'b0, cpt_pkg::SQRT3_HALF_Q16});

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv_w) begin
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         s5_mode_ff  <= s4_mode_ff;
         s5_alpha_ff <= s4_alpha_ff;
         s5_beta_ff  <= s4_beta_ff;
         s5_x_ff     <= s4_x_ff;
         s5_y_ff     <= s4_y_ff;
         s5_flag_ff  <= s4_flag_ff;
         s5_pb_ff    <= PW'(pb_w);
         s5_pa_ff    <= PW'(s4_alpha_ff) <<< 15;
      end
   end

   // --------------------------- stage 6: phases b and c, output register
   logic signed [PW-1:0] yn_w, zn_w;
   cpt_pkg::rsp_type     rsp_in;

   assign yn_w = div_pow2(s5_pb_ff - s5_pa_ff, 16);
   assign zn_w = div_pow2(-s5_pb_ff - s5_pa_ff, 16);

   always_comb begin
      rsp_in.out_alpha = s5_alpha_ff;
      rsp_in.out_beta  = s5_beta_ff;
      rsp_in.out_x     = s5_x_ff;
      if (s5_mode_ff == cpt_pkg::MODE_FORWARD) begin
         rsp_in.out_y     = s5_y_ff;
         rsp_in.out_z     = '0;
         rsp_in.saturated = s5_flag_ff;
      end else begin
         rsp_in.out_y     = sat_data(yn_w);
         rsp_in.out_z     = sat_data(zn_w);
         rsp_in.saturated = s5_flag_ff | is_over(yn_w) | is_over(zn_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_w) begin
         rsp_valid_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // ------------------------------------------------------------ checks
   a_sincos_range: assert property (@(posedge clock) disable iff (reset)
      sa_v_ff |-> (sa_cs_ff != {1'b1, {(SW-1){1'b0}}}) && (sa_sn_ff != {1'b1, {(SW-1){1'b0}}}))
      else $error("sine or cosine outside symmetric Q1.15 range");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv_w |=> $stable(sa_v_ff) && $stable(s3_v_ff) && $stable(s5_v_ff) && $stable(cv_ff[0]))
      else $error("pipeline valid bit moved while the response was held");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (s5_v_ff && adv_w) |=> rsp_valid)
      else $error("transaction lost between last stage and output");

   a_freeze_data: assert property (@(posedge clock) disable iff (reset)
      !adv_w |=> $stable(s4_alpha_ff) && $stable(s4_flag_ff))
      else $error("stage data moved while the response was held");

endmodule

`default_nettype wire
